### src/pcg_pkg.sv
// Shared types and constants for the plate character grouper.
`timescale 1ns / 1ps
package pcg_pkg;

  localparam int DefMaxBoxes  = 256;
  localparam int DefCoordBits = 12;
  localparam int AreaBits     = 24;
  localparam int GapBits      = 12;
  localparam int CountBits    = 8;
  localparam int CfgIdxBits   = 2;

  localparam logic [CfgIdxBits-1:0] CFG_MIN_AREA  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_AREA  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_X_GAP = 2'd2;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,     // waiting for a queued box
    ST_INS_RD,   // insertion sort: issue read of element i (the key)
    ST_INS_CMP,  // compare, shift or place
    ST_SCAN_I,   // scan: read box i
    ST_SCAN_IW,  // wait for box i data
    ST_SCAN_J,   // read box j
    ST_SCAN_JW,  // evaluate box j
    ST_RESULT    // present result
  } seq_state_t;

endpackage

### src/plate_character_grouper.sv
// A box is registered in the front stage before it is pushed into the queue; boxes enter at
// one per cycle while in_stall is low. After the last box, an insertion sort and
// a neighbor scan (bounded by the x gap) run on the box RAM.
// The result is held until taken; new boxes queue up meanwhile (four deep).
// Reset (synchronous, rst_n low) empties the store and restores the area and gap limits.
`timescale 1ns / 1ps
module plate_character_grouper
  import pcg_pkg::*;
#(
  parameter int MaxBoxes  = DefMaxBoxes,
  parameter int CoordBits = DefCoordBits
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [AreaBits-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CoordBits-1:0]  in_box_x,
  input  logic [CoordBits-1:0]  in_box_y,
  input  logic [CoordBits:0]    in_box_width,
  input  logic [CoordBits:0]    in_box_height,
  input  logic                  in_last_box,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [CoordBits-1:0]  out_sel_x,
  output logic [CoordBits-1:0]  out_sel_y,
  output logic [CoordBits:0]    out_sel_width,
  output logic [CoordBits:0]    out_sel_height,
  output logic [CoordBits-1:0]  out_plate_span,
  output logic [CountBits-1:0]  out_neighbor_count
);
  localparam int BW = 4 * CoordBits + 2;

  logic [AreaBits-1:0] min_area_r, max_area_r;
  logic [GapBits-1:0]  max_x_gap_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_area_r  <= AreaBits'(100);
      max_area_r  <= AreaBits'(700);
      max_x_gap_r <= GapBits'(150);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_AREA:  min_area_r  <= cfg_data;
        CFG_MAX_AREA:  max_area_r  <= cfg_data;
        CFG_MAX_X_GAP: max_x_gap_r <= cfg_data[GapBits-1:0];
        default: ;
      endcase
    end
  end

  logic push, full, pop, empty, keep, last;
  logic [BW-1:0] box;
  logic [BW+1:0] qw, qr;

  pcg_front #(.CoordBits(CoordBits)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .box_x(in_box_x), .box_y(in_box_y), .box_width(in_box_width),
    .box_height(in_box_height), .last_box(in_last_box),
    .min_area(min_area_r), .max_area(max_area_r),
    .q_push(push), .q_keep(keep), .q_last(last), .q_box(box), .q_full(full)
  );

  assign qw = {keep, last, box};

  pcg_queue #(.Width(BW + 2)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(qw), .full(full),
    .pop(pop), .rdata(qr), .empty(empty)
  );

  pcg_back #(.MaxBoxes(MaxBoxes), .CoordBits(CoordBits)) u_back (
    .clk(clk), .rst_n(rst_n), .max_x_gap(max_x_gap_r),
    .q_empty(empty), .q_keep(qr[BW+1]), .q_last(qr[BW]), .q_box(qr[BW-1:0]),
    .q_pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .found(out_found), .sel_x(out_sel_x), .sel_y(out_sel_y),
    .sel_width(out_sel_width), .sel_height(out_sel_height),
    .plate_span(out_plate_span), .neighbor_count(out_neighbor_count)
  );
endmodule

### src/pcg_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module pcg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/pcg_front.sv
// Front end: classifies incoming boxes and pushes every box into the queue with its keep flag.
`timescale 1ns / 1ps
module pcg_front
  import pcg_pkg::*;
#(
  parameter int CoordBits = DefCoordBits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CoordBits-1:0] box_x,
  input  logic [CoordBits-1:0] box_y,
  input  logic [CoordBits:0]   box_width,
  input  logic [CoordBits:0]   box_height,
  input  logic                 last_box,
  input  logic [AreaBits-1:0]  min_area,
  input  logic [AreaBits-1:0]  max_area,
  // queue push side
  output logic                 q_push,
  output logic                 q_keep,
  output logic                 q_last,
  output logic [4*CoordBits+1:0] q_box,
  input  logic                 q_full
);
  localparam int SzBits = CoordBits + 1;

  // Stage 1 registers: box, area product and ratio test.
  logic                  v_r, v_nxt;
  logic                  last_r;
  logic                  rat_r;
  logic [4*CoordBits+1:0] box_r;
  logic [2*SzBits-1:0]   area_r;
  logic                  acc;
  logic [SzBits+1:0]     h2, w5;

  assign in_stall = v_r && q_full;
  assign acc      = in_valid && !in_stall;
  assign h2 = {1'b0, box_height, 1'b0};
  assign w5 = {2'b00, box_width} + {box_width, 2'b00};

  always_comb begin
    v_nxt = v_r;
    if (acc) v_nxt = 1'b1;
    else if (!q_full) v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= v_nxt;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      box_r  <= {box_x, box_y, box_width, box_height};
      last_r <= last_box;
      area_r <= box_width * box_height;
      rat_r  <= (box_width != '0) && (box_height != '0) &&
                (h2 >= {2'b00, box_width}) && (h2 <= w5);
    end
  end

  // Area test in the stage after the multiply.
  assign q_push = v_r && !q_full;
  assign q_last = last_r;
  assign q_box  = box_r;
  assign q_keep = rat_r &&
                  ({{(AreaBits+2){1'b0}}, area_r} >= {{(2*SzBits+2){1'b0}}, min_area}) &&
                  ({{(AreaBits+2){1'b0}}, area_r} <= {{(2*SzBits+2){1'b0}}, max_area});
endmodule

### src/pcg_back.sv
// Back end: stores kept boxes, sorts them by x and scans for the best row start.
`timescale 1ns / 1ps
module pcg_back
  import pcg_pkg::*;
#(
  parameter int MaxBoxes  = DefMaxBoxes,
  parameter int CoordBits = DefCoordBits
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [GapBits-1:0]     max_x_gap,
  // queue pop side
  input  logic                   q_empty,
  input  logic                   q_keep,
  input  logic                   q_last,
  input  logic [4*CoordBits+1:0] q_box,
  output logic                   q_pop,
  // results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [CoordBits-1:0]   sel_x,
  output logic [CoordBits-1:0]   sel_y,
  output logic [CoordBits:0]     sel_width,
  output logic [CoordBits:0]     sel_height,
  output logic [CoordBits-1:0]   plate_span,
  output logic [CountBits-1:0]   neighbor_count
);
  localparam int AW = $clog2(MaxBoxes);
  localparam int NW = $clog2(MaxBoxes + 1);
  localparam int BW = 4 * CoordBits + 2;
  localparam int CW = NW;

  seq_state_t st_r, st_nxt;

  logic [NW-1:0] n_r, n_nxt;         // kept count
  logic [NW-1:0] i_r, i_nxt;         // sort outer / scan i
  logic [NW-1:0] j_r, j_nxt;         // sort inner / scan j
  logic [BW-1:0] key_r, key_nxt;     // sort key / scan box i
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [CoordBits-1:0] span_r, span_nxt;
  logic [BW-1:0] sel_r, sel_nxt;
  logic          found_r, found_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [BW-1:0] wdata, rdata;

  pcg_ram #(.Width(BW), .Depth(MaxBoxes)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Field views of the key and read data.
  logic [CoordBits-1:0] kx, ky, rx, ry, dx, dy, dx1, dy1;
  logic                 far;
  logic                 near;
  assign kx = key_r[BW-1 -: CoordBits];
  assign ky = key_r[BW-1-CoordBits -: CoordBits];
  assign rx = rdata[BW-1 -: CoordBits];
  assign ry = rdata[BW-1-CoordBits -: CoordBits];
  assign dx = (rx >= kx) ? rx - kx : kx - rx;
  assign dy = (ry >= ky) ? ry - ky : ky - ry;
  assign far = {{(GapBits+1){1'b0}}, dx} > {{(CoordBits+1){1'b0}}, max_x_gap};
  assign dx1 = (dx == '0) ? CoordBits'(1) : dx;
  assign dy1 = (dy == '0) ? CoordBits'(1) : dy;
  assign near = {dy1, 2'b00} < {2'b00, dx1};

  // Next state and datapath.
  always_comb begin
    st_nxt = st_r; n_nxt = n_r; i_nxt = i_r; j_nxt = j_r; key_nxt = key_r;
    cnt_nxt = cnt_r; best_nxt = best_r; span_nxt = span_r;
    sel_nxt = sel_r; found_nxt = found_r; ov_nxt = ov_r;
    we = 1'b0; waddr = n_r[AW-1:0]; wdata = q_box; raddr = '0; q_pop = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_keep && n_r < NW'(MaxBoxes)) begin
            we = 1'b1;
            n_nxt = n_r + 1'b1;
          end
          if (q_last) begin
            i_nxt = NW'(1);
            best_nxt = '0; found_nxt = 1'b0; span_nxt = '0; sel_nxt = '0;
            st_nxt = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (i_r >= n_r) begin
          i_nxt = '0;
          st_nxt = ST_SCAN_I;
        end else begin
          raddr = i_r[AW-1:0];
          j_nxt = i_r;
          st_nxt = ST_INS_CMP;
          ov_nxt = 1'b0;
        end
      end
      ST_INS_CMP: begin
        // first cycle after RD: rdata is element i (key); later: element j-1
        if (!ov_r) begin
          key_nxt = rdata;
          ov_nxt = 1'b1;
          raddr = AW'(j_r - 1'b1);
        end else if (j_r != '0 && rx > kx) begin
          we = 1'b1; waddr = j_r[AW-1:0]; wdata = rdata;
          j_nxt = j_r - 1'b1;
          raddr = AW'(j_r - 2'd2);
          if (j_r == NW'(1)) begin
            we = 1'b1;
          end
        end else begin
          we = 1'b1; waddr = j_r[AW-1:0]; wdata = key_r;
          i_nxt = i_r + 1'b1;
          st_nxt = ST_INS_RD;
        end
        if (ov_r && j_r == NW'(1) && rx > kx) begin
          // element 0 shifted up, key goes to slot 0 next cycle
          st_nxt = ST_INS_CMP;
        end
      end
      ST_SCAN_I: begin
        if (i_r + 1'b1 >= n_r) begin
          st_nxt = ST_RESULT;
        end else begin
          raddr = i_r[AW-1:0];
          st_nxt = ST_SCAN_IW;
        end
      end
      ST_SCAN_IW: begin
        key_nxt = rdata;
        j_nxt = i_r + 1'b1;
        raddr = AW'(i_r + 1'b1);
        cnt_nxt = '0;
        st_nxt = ST_SCAN_JW;
      end
      ST_SCAN_J: begin
        raddr = j_r[AW-1:0];
        st_nxt = ST_SCAN_JW;
      end
      ST_SCAN_JW: begin
        if (far) begin
          j_nxt = n_r;
        end else begin
          if (near) cnt_nxt = cnt_r + 1'b1;
          j_nxt = j_r + 1'b1;
        end
        if (far || j_r + 1'b1 >= n_r) begin
          // finish box i
          if ((far ? cnt_r : cnt_r + CW'(near)) > best_r) begin
            best_nxt = far ? cnt_r : cnt_r + CW'(near);
            sel_nxt = key_r;
            span_nxt = far ? dx : dx1;
            found_nxt = 1'b1;
          end
          i_nxt = i_r + 1'b1;
          st_nxt = ST_SCAN_I;
        end else begin
          raddr = AW'(j_r + 1'b1);
          st_nxt = ST_SCAN_JW;
        end
      end
      ST_RESULT: begin
        if (!out_stall) begin
          n_nxt = '0;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      n_r  <= '0;
    end else begin
      st_r <= st_nxt;
      n_r  <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; key_r <= key_nxt; cnt_r <= cnt_nxt;
    best_r <= best_nxt; span_r <= span_nxt; sel_r <= sel_nxt;
    found_r <= found_nxt; ov_r <= ov_nxt;
  end

  // Result outputs.
  always_comb begin
    out_valid      = (st_r == ST_RESULT);
    found          = found_r;
    sel_x          = found_r ? sel_r[BW-1 -: CoordBits] : '0;
    sel_y          = found_r ? sel_r[BW-1-CoordBits -: CoordBits] : '0;
    sel_width      = found_r ? sel_r[2*CoordBits+1 -: CoordBits+1] : '0;
    sel_height     = found_r ? sel_r[CoordBits:0] : '0;
    plate_span     = found_r ? span_r : '0;
    neighbor_count = (best_r > CW'(255)) ? CountBits'(255) : best_r[CountBits-1:0];
  end
endmodule

### src/pcg_queue.sv
// Short FIFO between front and back ends.
`timescale 1ns / 1ps
module pcg_queue #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);
  logic [Width-1:0] mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = cnt_r == 3'd4;
  assign empty = cnt_r == 3'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {2'b00, push} - {2'b00, pop};
    end
  end
endmodule

### src/pcg_checker.sv
// Port-level checker for the plate character grouper, bound to the top level.
`timescale 1ns / 1ps
module pcg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [7:0]  out_neighbor_count,
  input logic [11:0] out_plate_span
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_neighbor_count == 8'd0 && out_plate_span == 12'd0)
    else $error("empty result not zero");
  a_f_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_neighbor_count != 8'd0)
    else $error("found without neighbor");
endmodule

bind plate_character_grouper pcg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_found(out_found), .out_neighbor_count(out_neighbor_count),
  .out_plate_span(out_plate_span)
);

### bench/tb_plate_character_grouper.sv
// Self-checking testbench for the plate character grouper: directed table, then random frames.
`timescale 1ns / 1ps
module tb_plate_character_grouper;
  import pcg_pkg::*;

  localparam int MaxBoxes = DefMaxBoxes;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } box_t;

  typedef struct {
    logic        found;
    logic [11:0] sel_x;
    logic [11:0] sel_y;
    logic [12:0] sel_width;
    logic [12:0] sel_height;
    logic [11:0] plate_span;
    logic [7:0]  neighbor_count;
  } group_t;

  typedef struct {
    box_t   b;
    logic   last;
    logic   typed;
    group_t grp;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [AreaBits-1:0]   cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [11:0]           in_box_x;
  logic [11:0]           in_box_y;
  logic [12:0]           in_box_width;
  logic [12:0]           in_box_height;
  logic                  in_last_box;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_found;
  logic [11:0]           out_sel_x;
  logic [11:0]           out_sel_y;
  logic [12:0]           out_sel_width;
  logic [12:0]           out_sel_height;
  logic [11:0]           out_plate_span;
  logic [7:0]            out_neighbor_count;

  plate_character_grouper dut (.*);

  // Local copy of the limits and of the current frame
  logic [23:0] lim_min_area;
  logic [23:0] lim_max_area;
  logic [11:0] lim_gap;
  box_t        frame_boxes[$];
  group_t      pending_groups[$];
  int          errors;
  int          cyc;

  initial begin
    clk = 1'b0;
  end
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Box filter: ratio [0.5, 2.5] and area window, store capacity
  function automatic void keep_box(input box_t b);
    longint unsigned area;
    area = longint'(b.w) * longint'(b.h);
    if (b.w != 0 && b.h != 0 && 2 * int'(b.h) >= int'(b.w) && 2 * int'(b.h) <= 5 * int'(b.w)
        && area >= lim_min_area && area <= lim_max_area && frame_boxes.size() < MaxBoxes)
      frame_boxes.push_back(b);
  endfunction

  // Stable sort by x, neighbor scan, pick the strictly best box
  function automatic group_t group_frame();
    box_t        s[$];
    box_t        key;
    group_t      g;
    int          j;
    int unsigned best, cnt, dx, dy, span, sel;
    s = frame_boxes;
    for (int i = 1; i < s.size(); i++) begin
      key = s[i];
      j = i;
      while (j > 0 && s[j-1].x > key.x) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = key;
    end
    best = 0; span = 0; sel = 0;
    g = '{default: '0};
    for (int i = 0; i + 1 < s.size(); i++) begin
      cnt = 0; dx = 0;
      for (int k = i + 1; k < s.size(); k++) begin
        dx = (s[k].x >= s[i].x) ? s[k].x - s[i].x : s[i].x - s[k].x;
        if (dx > lim_gap) break;
        dy = (s[k].y >= s[i].y) ? s[k].y - s[i].y : s[i].y - s[k].y;
        if (dx == 0) dx = 1;
        if (dy == 0) dy = 1;
        if (4 * dy < dx) cnt++;
      end
      if (cnt > best) begin
        best = cnt; sel = i; span = dx;
        g.found = 1'b1;
      end
    end
    if (g.found) begin
      g.sel_x = s[sel].x;
      g.sel_y = s[sel].y;
      g.sel_width = s[sel].w;
      g.sel_height = s[sel].h;
      g.plate_span = span[11:0];
      g.neighbor_count = (best > 255) ? 8'd255 : best[7:0];
    end
    frame_boxes.delete();
    return g;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One input transaction; returns at the edge where it was taken, or after a random idle gap
  task automatic send_box(input box_t b, input logic last, input logic typed, input group_t tg);
    group_t g;
    int gap;
    in_valid <= 1'b1;
    in_box_x <= b.x;
    in_box_y <= b.y;
    in_box_width <= b.w;
    in_box_height <= b.h;
    in_last_box <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    keep_box(b);
    if (last) begin
      g = group_frame();
      pending_groups.push_back(typed ? tg : g);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write only while idle: drain, then let the back end settle
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [23:0] val);
    in_valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_AREA) lim_min_area = val;
    else if (idx == CFG_MAX_AREA) lim_max_area = val;
    else lim_gap = val[11:0];
  endtask

  task automatic set_limits(input logic [23:0] lo, input logic [23:0] hi, input logic [11:0] gap);
    write_reg(CFG_MIN_AREA, lo);
    write_reg(CFG_MAX_AREA, hi);
    write_reg(CFG_MAX_X_GAP, {12'd0, gap});
  endtask

  function automatic box_t rand_box(input int base_x, input int base_y);
    box_t b;
    int w, h;
    if ($urandom_range(0, 3) == 0) begin
      // noise: any coordinates and sizes, zero included
      b.x = 12'($urandom);
      b.y = 12'($urandom);
      b.w = 13'($urandom_range(0, 4096));
      b.h = ($urandom_range(0, 1)) ? 13'($urandom_range(0, 4096)) : 13'($urandom_range(0, 40));
    end else begin
      w = $urandom_range(4, 30);
      h = $urandom_range((w + 1) / 2, (5 * w) / 2);
      if ($urandom_range(0, 9) == 0) h = $urandom_range(1, 80);
      b.x = 12'((base_x + $urandom_range(0, 300)) % 4096);
      b.y = 12'((base_y + $urandom_range(0, 40)) % 4096);
      b.w = 13'(w);
      b.h = 13'(h);
    end
    return b;
  endfunction

  // Result side: check every taken transaction, stall at random
  always @(posedge clk) begin
    group_t e;
    if (rst_n) begin
      cyc++;
      if (out_valid && !out_stall) begin
        if (pending_groups.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = pending_groups.pop_front();
          if (out_found !== e.found) report($sformatf("found %0d exp %0d", out_found, e.found));
          if (out_sel_x !== e.sel_x) report($sformatf("sel_x %0d exp %0d", out_sel_x, e.sel_x));
          if (out_sel_y !== e.sel_y) report($sformatf("sel_y %0d exp %0d", out_sel_y, e.sel_y));
          if (out_sel_width !== e.sel_width)
            report($sformatf("sel_width %0d exp %0d", out_sel_width, e.sel_width));
          if (out_sel_height !== e.sel_height)
            report($sformatf("sel_height %0d exp %0d", out_sel_height, e.sel_height));
          if (out_plate_span !== e.plate_span)
            report($sformatf("plate_span %0d exp %0d", out_plate_span, e.plate_span));
          if (out_neighbor_count !== e.neighbor_count)
            report($sformatf("count %0d exp %0d", out_neighbor_count, e.neighbor_count));
        end
      end
      // calm stretches with no stall alternate with noisy ones
      if ((cyc / 300) % 3 == 0) out_stall <= 1'b0;
      else out_stall <= (pick_gap() > 1);
    end
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    row_t   rows[$];
    row_t   r;
    group_t none;
    group_t pair;
    box_t   b;
    int     sent, n, bx, by;
    errors = 0; cyc = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_box_x = '0; in_box_y = '0; in_box_width = '0; in_box_height = '0;
    in_last_box = 1'b0; out_stall = 1'b0;
    lim_min_area = 24'd100; lim_max_area = 24'd700; lim_gap = 12'd150;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    none = '{default: '0};
    pair = '{1'b1, 12'd0, 12'd0, 13'd10, 13'd10, 12'd100, 8'd1};
    // directed table: x, y, w, h, last, typed, expected
    rows = '{
      '{'{12'd0, 12'd0, 13'd10, 13'd10}, 1'b1, 1'b1, none},        // lone box after reset
      '{'{12'd5, 12'd5, 13'd0, 13'd10}, 1'b0, 1'b0, none},         // zero width
      '{'{12'd5, 12'd5, 13'd10, 13'd0}, 1'b0, 1'b0, none},         // zero height
      '{'{12'd4095, 12'd4095, 13'd4096, 13'd4096}, 1'b0, 1'b0, none},
      '{'{12'd0, 12'd0, 13'd20, 13'd10}, 1'b0, 1'b0, none},        // ratio at 0.5
      '{'{12'd100, 12'd10, 13'd10, 13'd25}, 1'b0, 1'b0, none},     // ratio at 2.5
      '{'{12'd50, 12'd0, 13'd20, 13'd9}, 1'b0, 1'b0, none},        // just under 0.5
      '{'{12'd60, 12'd0, 13'd10, 13'd26}, 1'b0, 1'b0, none},       // just over 2.5
      '{'{12'd200, 12'd4095, 13'd10, 13'd10}, 1'b1, 1'b0, none},   // area at minimum
      '{'{12'd0, 12'd0, 13'd10, 13'd10}, 1'b0, 1'b0, none},
      '{'{12'd100, 12'd10, 13'd10, 13'd10}, 1'b1, 1'b1, pair},     // one aligned pair
      '{'{12'd0, 12'd0, 13'd28, 13'd25}, 1'b0, 1'b0, none},        // area at maximum
      '{'{12'd30, 12'd0, 13'd27, 13'd26}, 1'b0, 1'b0, none},       // area above maximum
      '{'{12'd30, 12'd0, 13'd12, 13'd12}, 1'b0, 1'b0, none},       // same y, same x pair
      '{'{12'd30, 12'd0, 13'd12, 13'd12}, 1'b0, 1'b0, none},
      '{'{12'd181, 12'd1, 13'd12, 13'd12}, 1'b1, 1'b0, none}       // just past the gap
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_box(r.b, r.last, r.typed, r.grp);
    end

    // random phases over several limit settings, extremes among them
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_limits(24'd0, 24'hFFFFFF, 12'd4095);
        1: set_limits(24'd0, 24'hFFFFFF, 12'd0);
        2: set_limits(24'd500, 24'd100, 12'd150);
        3: set_limits(24'd100, 24'd700, 12'd150);
        default: set_limits(24'($urandom_range(0, 300)), 24'($urandom_range(200, 2000)),
                            12'($urandom_range(0, 4095)));
      endcase
      if (ph == 0) begin
        // store overflow: more kept boxes than the store holds
        for (int k = 0; k < MaxBoxes + 4; k++) begin
          b.x = 12'($urandom); b.y = 12'($urandom_range(0, 20)); b.w = 13'd10; b.h = 13'd10;
          send_box(b, k == MaxBoxes + 3, 1'b0, none);
        end
      end
      while (sent < (ph + 1) * 55) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        bx = $urandom_range(0, 3800);
        by = $urandom_range(0, 4095);
        for (int k = 0; k < n; k++) begin
          b = rand_box(bx, by);
          send_box(b, k == n - 1, 1'b0, none);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### plate_character_grouper.f
src/pcg_pkg.sv
src/pcg_ram.sv
src/pcg_front.sv
src/pcg_back.sv
src/pcg_queue.sv
src/plate_character_grouper.sv
src/pcg_checker.sv
bench/tb_plate_character_grouper.sv
